// File: design/gwm_pkg.sv
// shared constants and types for the glob wildcard matcher
package gwm_pkg;

  localparam int MAX_PATTERN_CHARS = 32;
  localparam int CHAR_W            = 8;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_INDEX_W       = 3;
  localparam int LENGTH_W          = 6;
  localparam int PATTERN_WORDS     = 4;
  localparam int PATTERN_BITS      = PATTERN_WORDS * CFG_DATA_W;

  localparam logic [CHAR_W-1:0] CHAR_ANY_ONE = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_ANY_RUN = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHARS_LOW    = 3'd0,
    CFG_CHARS_SECOND = 3'd1,
    CFG_CHARS_THIRD  = 3'd2,
    CFG_CHARS_HIGH   = 3'd3,
    CFG_LENGTH       = 3'd4
  } cfg_reg_t;

endpackage

// File: design/gwm_if.sv
// item channels: name bytes in, match flags out
interface gwm_name_if;
  logic                       valid;
  logic                       ready;
  logic [gwm_pkg::CHAR_W-1:0] name_char;
  logic                       end_of_name;

  modport source (output valid, output name_char, output end_of_name, input ready);
  modport sink   (input valid, input name_char, input end_of_name, output ready);
endinterface

interface gwm_match_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// File: design/gwm_step.sv
// one step of the active position vector: star closure, byte advance, closure again
module gwm_step #(
  parameter int MAX_PATTERN_CHARS = gwm_pkg::MAX_PATTERN_CHARS
) (
  input  logic [MAX_PATTERN_CHARS:0]                  active,
  input  logic [MAX_PATTERN_CHARS*gwm_pkg::CHAR_W-1:0] pattern,
  input  logic [MAX_PATTERN_CHARS:0]                  keep_mask,
  input  logic [MAX_PATTERN_CHARS:0]                  end_mask,
  input  logic [MAX_PATTERN_CHARS-1:0]                star_mask,
  input  logic [MAX_PATTERN_CHARS-1:0]                any_mask,
  input  logic [MAX_PATTERN_CHARS-1:0]                lit_mask,
  input  logic [gwm_pkg::CHAR_W-1:0]                  name_char,
  output logic [MAX_PATTERN_CHARS:0]                  next_active,
  output logic                                        matched
);

  localparam int ActW = MAX_PATTERN_CHARS + 1;

  logic [ActW-1:0]              closed;
  logic [ActW-1:0]              stepped;
  logic [ActW-1:0]              star_ext;
  logic [MAX_PATTERN_CHARS-1:0] char_eq;
  logic [MAX_PATTERN_CHARS-1:0] advance;

  // log-depth prefix: bit i reaches bit i+d when pattern bytes i..i+d-1 are all stars
  function automatic logic [ActW-1:0] close_run(input logic [ActW-1:0] v,
                                                input logic [ActW-1:0] p);
    logic [ActW-1:0] g;
    logic [ActW-1:0] pp;
    g  = v;
    pp = p;
    for (int s = 1; s < ActW; s = s * 2) begin
      g  = g | ((g & pp) << s);
      pp = pp & (pp >> s);
    end
    return g;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      char_eq[i] = (pattern[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W] == name_char);
    end
  end

  assign star_ext = {1'b0, star_mask};
  assign closed   = close_run(active & keep_mask, star_ext);
  assign advance  = closed[MAX_PATTERN_CHARS-1:0] & (any_mask | (lit_mask & char_eq));
  // a star keeps its own position, anything else that matches moves up by one
  assign stepped  = {advance, 1'b0} | {1'b0, closed[MAX_PATTERN_CHARS-1:0] & star_mask};

  assign next_active = close_run(stepped & keep_mask, star_ext);
  assign matched     = |(closed & end_mask);

endmodule

// File: design/glob_wildcard_matcher.sv
// glob matcher top level: config registers, input register, step logic, result register
//
//  channel   dir  handshake        payload
//  name_in   in   valid / ready    name_char[7:0], end_of_name
//  match_out out  valid / ready    matched
//  cfg       in   cfg_we           cfg_index[2:0], cfg_data[63:0]
//
//  one item per cycle while no end-of-name item waits on a stalled result; a
//  result passes the input register and the result register around gwm_step
//  pattern masks are decoded straight from the config registers, so a write
//  applies to every item taken from that edge on
//  sync reset empties both registers and restarts at pattern position zero
//  a stalled result holds only an end-of-name item; name bytes keep flowing
module glob_wildcard_matcher #(
  parameter int MAX_PATTERN_CHARS = gwm_pkg::MAX_PATTERN_CHARS
) (
  input  logic                                clk,
  input  logic                                rst,
  gwm_name_if.sink                            name_in,
  gwm_match_if.source                         match_out,
  input  logic                                cfg_we,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ActW = MAX_PATTERN_CHARS + 1;
  localparam logic [gwm_pkg::LENGTH_W-1:0] LenMax = gwm_pkg::LENGTH_W'(MAX_PATTERN_CHARS);

  // configuration
  logic [gwm_pkg::PATTERN_WORDS-1:0][gwm_pkg::CFG_DATA_W-1:0] pattern_words;
  logic [gwm_pkg::LENGTH_W-1:0]                               pattern_length;
  logic [gwm_pkg::PATTERN_BITS-1:0]                           pattern_flat;

  // derived pattern masks
  logic [ActW-1:0]              keep_mask;
  logic [ActW-1:0]              end_mask;
  logic [MAX_PATTERN_CHARS-1:0] star_mask;
  logic [MAX_PATTERN_CHARS-1:0] any_mask;
  logic [MAX_PATTERN_CHARS-1:0] lit_mask;
  logic [MAX_PATTERN_CHARS-1:0] in_use;
  logic [gwm_pkg::LENGTH_W-1:0] len_sat;
  logic                         stop;

  // item path
  logic                         in_valid;
  logic [gwm_pkg::CHAR_W-1:0]   in_char;
  logic                         in_end;
  logic                         out_valid;
  logic                         out_matched;
  logic                         proceed;
  logic                         take;
  logic [ActW-1:0]              active;
  logic [ActW-1:0]              step_active;
  logic                         step_matched;

  assign pattern_flat = pattern_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      case (gwm_pkg::cfg_reg_t'(cfg_index))
        gwm_pkg::CFG_CHARS_LOW:    pattern_words[0] <= cfg_data;
        gwm_pkg::CFG_CHARS_SECOND: pattern_words[1] <= cfg_data;
        gwm_pkg::CFG_CHARS_THIRD:  pattern_words[2] <= cfg_data;
        gwm_pkg::CFG_CHARS_HIGH:   pattern_words[3] <= cfg_data;
        gwm_pkg::CFG_LENGTH:       pattern_length   <= cfg_data[gwm_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // the pattern ends at the length or at its first zero byte, whichever comes first
  always_comb begin
    len_sat   = (pattern_length > LenMax) ? LenMax : pattern_length;
    stop      = 1'b0;
    end_mask  = '0;
    in_use    = '0;
    star_mask = '0;
    any_mask  = '0;
    lit_mask  = '0;
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      if (!stop && ((gwm_pkg::LENGTH_W'(i) >= len_sat) ||
                    (pattern_flat[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W] == gwm_pkg::CHAR_NUL)))
      begin
        stop        = 1'b1;
        end_mask[i] = 1'b1;
      end
      in_use[i]    = !stop;
      star_mask[i] = !stop &&
        (pattern_flat[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W] == gwm_pkg::CHAR_ANY_RUN);
      any_mask[i]  = !stop &&
        (pattern_flat[gwm_pkg::CHAR_W*i +: gwm_pkg::CHAR_W] == gwm_pkg::CHAR_ANY_ONE);
      lit_mask[i]  = !stop && !star_mask[i];
    end
    if (!stop) begin
      end_mask[MAX_PATTERN_CHARS] = 1'b1;
    end
    keep_mask = {in_use, 1'b1};
  end

  // name bytes never wait; an end-of-name item waits for room in the result register
  assign proceed       = !in_end || !out_valid || match_out.ready;
  assign name_in.ready = !in_valid || proceed;
  assign take          = name_in.valid && name_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (name_in.ready) begin
      in_valid <= name_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_char <= name_in.name_char;
      in_end  <= name_in.end_of_name;
    end
  end

  gwm_step #(
    .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
  ) u_step (
    .active      (active),
    .pattern     (pattern_flat[MAX_PATTERN_CHARS*gwm_pkg::CHAR_W-1:0]),
    .keep_mask   (keep_mask),
    .end_mask    (end_mask),
    .star_mask   (star_mask),
    .any_mask    (any_mask),
    .lit_mask    (lit_mask),
    .name_char   (in_char),
    .next_active (step_active),
    .matched     (step_matched)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ActW'(1);
    end else if (in_valid && proceed) begin
      active <= in_end ? ActW'(1) : step_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_end && proceed) begin
      out_valid <= 1'b1;
    end else if (match_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_end && proceed) begin
      out_matched <= step_matched;
    end
  end

  assign match_out.valid   = out_valid;
  assign match_out.matched = out_matched;

endmodule

// File: design/gwm_checker.sv
// port-level checks for the glob matcher, bound to the top level
module gwm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_end,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  // reset leaves no result pending and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

  // a stalled result holds its flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_matched))
    else $error("result dropped or changed while stalled");

  // a fresh result comes from an end-of-name item taken earlier through the input register
  a_rise_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end, 2))
    else $error("result without an end-of-name item");

  // name bytes are never back-pressured while no result is waiting
  a_open_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input closed with the result register empty");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (name_in.valid),
  .in_ready    (name_in.ready),
  .in_end      (name_in.end_of_name),
  .out_valid   (match_out.valid),
  .out_ready   (match_out.ready),
  .out_matched (match_out.matched)
);
